/* rtl/rgbhsv_pkg.sv */
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Types and constants shared by the RGB to HSV converter pipeline.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

	// Hue in 1/64 degree: one sixth of the circle, the green and blue sector bases, the full circle and its maximum
	localparam logic [14:0] HUE_SIXTH = 15'd3840;
	localparam logic [14:0] HUE_GREEN = 15'd7680;
	localparam logic [14:0] HUE_BLUE  = 15'd15360;
	localparam logic [14:0] HUE_FULL  = 15'd23040;
	localparam logic [14:0] HUE_MAX   = 15'd23039;

	// Quotient bits, one per divider cell
	localparam int unsigned DIV_STEPS = 16;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} pixel_in_t;

	typedef struct packed {
		logic [14:0] hue_out;
		logic [15:0] saturation_out;
		logic [7:0]  value_out;
		logic        achromatic;
	} pixel_out_t;

	// One restoring-division lane: partial remainder, numerator bits
	// shifting out on top while quotient bits shift in below, divisor
	typedef struct packed {
		logic [7:0]  rem;
		logic [15:0] work;
		logic [7:0]  dvs;
	} div_lane_t;

	// Information riding alongside the divisions
	typedef struct packed {
		logic [14:0] base;
		logic        neg;
		logic [7:0]  value;
		logic        achro;
	} side_t;

	typedef struct packed {
		div_lane_t sat;
		div_lane_t hue;
		side_t     side;
	} pipe_t;

endpackage

/* rtl/rgb_to_hsv_converter.sv */
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Pixel-rate RGB to HSV conversion through a chain of divider cells.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------
//  in      | in_valid / in_stall    | pixel_in_t  (red, green, blue)
//  out     | out_valid / out_stall  | pixel_out_t (hue, sat, value, flag)
//
//  One pixel per clock while out_stall is low, through a front stage, a
//  chain of 16 division cells (one quotient bit each for saturation and hue),
//  and an output stage.
//  Every stage holds its own valid bit, so bubbles close up under stall and
//  a new pixel is taken while a finished result waits at the output, as long
//  as some stage of the chain is empty; only a full chain stalls the input.
//  Reset clears only the valid bits; the chain is empty after reset.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  rgbhsv_pkg::pixel_in_t  in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output rgbhsv_pkg::pixel_out_t out_data
);

	localparam int unsigned N = rgbhsv_pkg::DIV_STEPS;

	logic              chain_valid [N+1];
	logic              chain_stall [N+1];
	rgbhsv_pkg::pipe_t chain_data  [N+1];

	// Operand preparation
	rgbhsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (chain_valid[0]),
		.out_stall (chain_stall[0]),
		.out_data  (chain_data[0])
	);

	// Division chain
	for (genvar i = 0; i < N; i++) begin : g_cell
		rgbhsv_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_stall  (chain_stall[i]),
			.in_data   (chain_data[i]),
			.out_valid (chain_valid[i+1]),
			.out_stall (chain_stall[i+1]),
			.out_data  (chain_data[i+1])
		);
	end

	// Hue assembly and output register
	rgbhsv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_valid[N]),
		.in_stall  (chain_stall[N]),
		.in_data   (chain_data[N]),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// Achromatic results carry zero hue and saturation
	a_achro_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.achromatic |->
			out_data.hue_out == 15'd0 && out_data.saturation_out == 16'd0)
		else $error("achromatic transaction with nonzero hue or saturation");

	// Hue stays below the full circle
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.hue_out < rgbhsv_pkg::HUE_FULL)
		else $error("hue out of range");

	// A chromatic pixel has a nonzero value
	a_value_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.achromatic |-> out_data.value_out != 8'd0)
		else $error("chromatic transaction with zero value");

	// Input backpressure only when the whole chain is full up to the output
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output not blocked");

endmodule

/* rtl/rgbhsv_front.sv */
// ----------------------------------------------------------------------------
// rgbhsv_front
// First stage: max/min, hue sector selection and division operands.
// ----------------------------------------------------------------------------
module rgbhsv_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  rgbhsv_pkg::pixel_in_t in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output rgbhsv_pkg::pipe_t     out_data
);

	logic [7:0]  r, g, b;
	logic [7:0]  mx, mn, d;
	logic [7:0]  p, q, x;
	logic [14:0] base;
	logic        neg;
	logic [23:0] sat_num;
	logic [19:0] hue_num;
	logic        valid_s1;
	rgbhsv_pkg::pipe_t data_s1;
	rgbhsv_pkg::pipe_t data_d;

	assign r = in_data.red_in;
	assign g = in_data.green_in;
	assign b = in_data.blue_in;

	// Sector pick: red wins ties over green, green over blue
	always_comb begin
		if (r >= g && r >= b) begin
			mx   = r;
			p    = g;
			q    = b;
			base = (g < b) ? rgbhsv_pkg::HUE_FULL : 15'd0;
		end else if (g >= b) begin
			mx   = g;
			p    = b;
			q    = r;
			base = rgbhsv_pkg::HUE_GREEN;
		end else begin
			mx   = b;
			p    = r;
			q    = g;
			base = rgbhsv_pkg::HUE_BLUE;
		end
		mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
	end

	assign d   = mx - mn;
	assign neg = (p < q);
	assign x   = neg ? (q - p) : (p - q);

	// 65535*d and 3840*x as shifts and subtracts
	assign sat_num = {d, 16'd0} - {16'd0, d};
	assign hue_num = {x, 12'd0} - {4'd0, x, 8'd0};

	always_comb begin
		data_d.sat.rem   = sat_num[23:16];
		data_d.sat.work  = sat_num[15:0];
		data_d.sat.dvs   = mx;
		data_d.hue.rem   = {4'd0, hue_num[19:16]};
		data_d.hue.work  = hue_num[15:0];
		data_d.hue.dvs   = d;
		data_d.side.base  = base;
		data_d.side.neg   = neg;
		data_d.side.value = mx;
		data_d.side.achro = (d == 8'd0);
	end

	assign in_stall = valid_s1 && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

/* rtl/rgbhsv_div_cell.sv */
// ----------------------------------------------------------------------------
// rgbhsv_div_cell
// One restoring-division step for both lanes, one quotient bit per cell.
// ----------------------------------------------------------------------------
module rgbhsv_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  rgbhsv_pkg::pipe_t in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output rgbhsv_pkg::pipe_t out_data
);

	logic              valid_q;
	rgbhsv_pkg::pipe_t data_q;
	rgbhsv_pkg::pipe_t data_d;

	function automatic rgbhsv_pkg::div_lane_t div_step(input rgbhsv_pkg::div_lane_t l);
		rgbhsv_pkg::div_lane_t o;
		logic [8:0] t;
		logic       take;
		t    = {l.rem, l.work[15]};
		take = (t >= {1'b0, l.dvs});
		o.rem  = take ? 8'(t - {1'b0, l.dvs}) : t[7:0];
		o.work = {l.work[14:0], take};
		o.dvs  = l.dvs;
		return o;
	endfunction

	always_comb begin
		data_d.sat  = div_step(in_data.sat);
		data_d.hue  = div_step(in_data.hue);
		data_d.side = in_data.side;
	end

	assign in_stall = valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_q <= data_d;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

/* rtl/rgbhsv_back.sv */
// ----------------------------------------------------------------------------
// rgbhsv_back
// Last stage: hue from sector base and quotient, achromatic override,
// output register.
// ----------------------------------------------------------------------------
module rgbhsv_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  rgbhsv_pkg::pipe_t      in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output rgbhsv_pkg::pixel_out_t out_data
);

	logic [15:0] hue_sum;
	logic [14:0] hue;
	logic        round_up;
	logic        valid_q;
	rgbhsv_pkg::pixel_out_t res_d;
	rgbhsv_pkg::pixel_out_t res_q;

	// Negative offsets truncate toward the base, so a nonzero remainder
	// takes one more unit off
	assign round_up = (in_data.hue.rem != 8'd0);

	always_comb begin
		if (in_data.side.neg) begin
			hue_sum = {1'b0, in_data.side.base} - {4'd0, in_data.hue.work[11:0]}
				- {15'd0, round_up};
		end else begin
			hue_sum = {1'b0, in_data.side.base} + {4'd0, in_data.hue.work[11:0]};
		end
		hue = (hue_sum >= {1'b0, rgbhsv_pkg::HUE_FULL}) ? rgbhsv_pkg::HUE_MAX
			: hue_sum[14:0];
	end

	always_comb begin
		res_d.value_out  = in_data.side.value;
		res_d.achromatic = in_data.side.achro;
		if (in_data.side.achro) begin
			res_d.hue_out        = 15'd0;
			res_d.saturation_out = 16'd0;
		end else begin
			res_d.hue_out        = hue;
			res_d.saturation_out = in_data.sat.work;
		end
	end

	assign in_stall = valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			res_q <= res_d;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = res_q;

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rgb_to_hsv_converter. A table of directed pixels
// (extremes, gray, channel ties, hue wrap) is followed by biased random pixels
// under four traffic phases. Every accepted result is checked in order against
// its expected result, from the table or from an integer HSV predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES   = 40;
	localparam int unsigned ITEMS_PER_PHASE = 420;

	typedef struct {
		rgbhsv_pkg::pixel_in_t  px;
		bit                     typed;
		rgbhsv_pkg::pixel_out_t res;
	} dir_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	rgbhsv_pkg::pixel_in_t  in_data = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	rgbhsv_pkg::pixel_out_t out_data;

	// Expected result that travels with the pixel currently on in_data
	rgbhsv_pkg::pixel_out_t hsv_pending = '0;
	rgbhsv_pkg::pixel_out_t hsv_expected[$];
	dir_row_t               dir_rows[$];

	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;

	rgb_to_hsv_converter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// HSV predictor, exact integer arithmetic, hue in 1/64 degree
	function automatic rgbhsv_pkg::pixel_out_t predict_hsv(rgbhsv_pkg::pixel_in_t px);
		rgbhsv_pkg::pixel_out_t res;
		int unsigned r, g, b, mx, mn, d, num, base, hue, sixth;
		r = 32'(px.red_in);
		g = 32'(px.green_in);
		b = 32'(px.blue_in);
		sixth = 32'(rgbhsv_pkg::HUE_SIXTH);
		mx = (r > g) ? r : g;
		mx = (mx > b) ? mx : b;
		mn = (r < g) ? r : g;
		mn = (mn < b) ? mn : b;
		d = mx - mn;
		res = '0;
		res.value_out = mx[7:0];
		if (d == 32'd0) begin
			res.achromatic = 1'b1;
		end else begin
			res.saturation_out = 16'((32'd65535 * d) / mx);
			// first maximal channel wins: red, then green, then blue
			if (mx == r) begin
				base = (g < b) ? 32'(rgbhsv_pkg::HUE_FULL) : 32'd0;
				num = (g >= b) ? base * d + sixth * (g - b)
				               : base * d - sixth * (b - g);
			end else if (mx == g) begin
				base = 32'(rgbhsv_pkg::HUE_GREEN);
				num = (b >= r) ? base * d + sixth * (b - r)
				               : base * d - sixth * (r - b);
			end else begin
				base = 32'(rgbhsv_pkg::HUE_BLUE);
				num = (r >= g) ? base * d + sixth * (r - g)
				               : base * d - sixth * (g - r);
			end
			hue = num / d;
			if (hue >= 32'(rgbhsv_pkg::HUE_FULL))
				hue = 32'(rgbhsv_pkg::HUE_MAX);
			res.hue_out = hue[14:0];
		end
		return res;
	endfunction

	// Biased random pixel: mostly uniform, plus ties, gray, corners, near-gray
	function automatic rgbhsv_pkg::pixel_in_t rand_pixel();
		rgbhsv_pkg::pixel_in_t px;
		logic [7:0]  corner [4];
		logic [7:0]  v;
		int unsigned mode;
		corner = '{8'd0, 8'd1, 8'd254, 8'd255};
		mode = $urandom_range(9);
		px.red_in = 8'($urandom);
		px.green_in = 8'($urandom);
		px.blue_in = 8'($urandom);
		case (mode)
			6: begin
				case ($urandom_range(2))
					0: px.green_in = px.red_in;
					1: px.blue_in = px.green_in;
					default: px.blue_in = px.red_in;
				endcase
			end
			7: begin
				px.green_in = px.red_in;
				px.blue_in = px.red_in;
			end
			8: begin
				px.red_in = corner[$urandom_range(3)];
				px.green_in = corner[$urandom_range(3)];
				px.blue_in = corner[$urandom_range(3)];
			end
			9: begin
				v = px.red_in;
				px.green_in = v + 8'($urandom_range(2)) - 8'd1;
				px.blue_in = v + 8'($urandom_range(2)) - 8'd1;
			end
			default: ;
		endcase
		return px;
	endfunction

	task automatic add_row(input int r, input int g, input int b, input bit typed,
	                       input int h, input int s, input int v, input bit a);
		dir_row_t row;
		row.px = '{red_in: 8'(r), green_in: 8'(g), blue_in: 8'(b)};
		row.typed = typed;
		row.res = '{hue_out: 15'(h), saturation_out: 16'(s), value_out: 8'(v),
		            achromatic: a};
		dir_rows.push_back(row);
	endtask

	// Offer one pixel, with random idle cycles first; returns after acceptance
	task automatic send_pixel(input rgbhsv_pkg::pixel_in_t px,
	                          input rgbhsv_pkg::pixel_out_t res);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= px;
		hsv_pending <= res;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic note_mismatch(input string what, input rgbhsv_pkg::pixel_out_t want,
	                             input rgbhsv_pkg::pixel_out_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t %s: exp h=%0d s=%0d v=%0d a=%0b got h=%0d s=%0d v=%0d a=%0b",
			         $realtime, what, want.hue_out, want.saturation_out,
			         want.value_out, want.achromatic, got.hue_out,
			         got.saturation_out, got.value_out, got.achromatic);
	endtask

	// Receiver backpressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Record accepted pixels and check accepted results
	always @(posedge clk) begin
		rgbhsv_pkg::pixel_out_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				hsv_expected.push_back(hsv_pending);
			if (out_valid && !out_stall) begin
				if (hsv_expected.size() == 0) begin
					note_mismatch("unexpected result", '0, out_data);
				end else begin
					want = hsv_expected.pop_front();
					if (out_data.hue_out !== want.hue_out ||
					    out_data.saturation_out !== want.saturation_out ||
					    out_data.value_out !== want.value_out ||
					    out_data.achromatic !== want.achromatic)
						note_mismatch("mismatch", want, out_data);
				end
			end
		end
	end

	// Watchdog: too many cycles with no transaction on either channel
	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// Main sequence
	initial begin
		int unsigned           phase_idle [4];
		int unsigned           phase_stall [4];
		rgbhsv_pkg::pixel_in_t px;
		phase_idle = '{0, 86, 0, 35};
		phase_stall = '{0, 0, 86, 35};

		// gray, primaries, ties and hue wrap with results known by inspection
		add_row(0, 0, 0, 1, 0, 0, 0, 1);
		add_row(255, 255, 255, 1, 0, 0, 255, 1);
		add_row(1, 1, 1, 1, 0, 0, 1, 1);
		add_row(255, 0, 0, 1, 0, 65535, 255, 0);
		add_row(0, 255, 0, 1, 7680, 65535, 255, 0);
		add_row(0, 0, 255, 1, 15360, 65535, 255, 0);
		add_row(255, 255, 0, 1, 3840, 65535, 255, 0);
		add_row(0, 255, 255, 1, 11520, 65535, 255, 0);
		add_row(255, 0, 255, 1, 19200, 65535, 255, 0);
		add_row(1, 0, 0, 1, 0, 65535, 1, 0);
		// the rest go through the predictor
		add_row(255, 0, 1, 0, 0, 0, 0, 0);
		add_row(255, 1, 0, 0, 0, 0, 0, 0);
		add_row(128, 128, 127, 0, 0, 0, 0, 0);
		add_row(127, 128, 128, 0, 0, 0, 0, 0);
		add_row(200, 100, 200, 0, 0, 0, 0, 0);
		add_row(10, 200, 200, 0, 0, 0, 0, 0);
		add_row(37, 91, 164, 0, 0, 0, 0, 0);
		add_row(254, 255, 255, 0, 0, 0, 0, 0);
		add_row(255, 254, 254, 0, 0, 0, 0, 0);
		add_row(0, 0, 1, 0, 0, 0, 0, 0);
		add_row(128, 64, 192, 0, 0, 0, 0, 0);
		add_row(255, 128, 128, 0, 0, 0, 0, 0);
		add_row(100, 100, 101, 0, 0, 0, 0, 0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_pixel(dir_rows[i].px,
			           dir_rows[i].typed ? dir_rows[i].res : predict_hsv(dir_rows[i].px));

		for (int p = 0; p < 4; p++) begin
			// sender holds off until the pipeline has fully drained
			in_valid <= 1'b0;
			while (hsv_expected.size() != 0)
				@(posedge clk);
			idle_pct = phase_idle[p];
			stall_pct = phase_stall[p];
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				px = rand_pixel();
				send_pixel(px, predict_hsv(px));
			end
		end
		in_valid <= 1'b0;

		while (hsv_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && hsv_expected.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
